// ----- sv/g2r_pkg.sv -----
// shared types, screen constants and the 5x7 font table of the glyph rasterizer
package g2r_pkg;

    // screen size
    localparam int unsigned SCREEN_W = 320;
    localparam int unsigned SCREEN_H = 240;

    // bits that hold any screen dimension up to 4096
    localparam int unsigned DIM_W = 13;

    // glyph geometry
    localparam int unsigned GLYPH_COLS = 5;
    localparam int unsigned GLYPH_ROWS = 7;
    localparam logic [2:0]  LAST_ROW   = 3'(GLYPH_ROWS - 1);
    localparam logic [2:0]  SPACE_COL  = 3'(GLYPH_COLS);

    // screen limits as 16 bit and DIM_W bit words
    localparam logic [15:0]      SCREEN_W16 = 16'(SCREEN_W);
    localparam logic [15:0]      SCREEN_H16 = 16'(SCREEN_H);
    localparam logic [DIM_W-1:0] SCREEN_WD  = DIM_W'(SCREEN_W);
    localparam logic [DIM_W-1:0] SCREEN_HD  = DIM_W'(SCREEN_H);

    // one glyph, column-major, bit 0 of a column is the top row
    typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

    // one character as handed from front to back
    typedef struct packed {
        logic [15:0] x0;
        logic [15:0] y0;
        logic [7:0]  cell_px;
        glyph_t      glyph;
        logic [15:0] fg;
        logic [15:0] bg;
    } cmd_t;

    // pack five font columns, first column in the low bits
    function automatic glyph_t pack_cols(input logic [6:0] c0, input logic [6:0] c1,
                                         input logic [6:0] c2, input logic [6:0] c3,
                                         input logic [6:0] c4);
        glyph_t g;
        g = {c4, c3, c2, c1, c0};
        return g;
    endfunction

    // font lookup, codes without a glyph give a blank
    function automatic glyph_t glyph_lookup(input logic [7:0] code);
        glyph_t g;
        case (code)
            "A":     g = pack_cols(7'h7E, 7'h09, 7'h09, 7'h09, 7'h7E);
            "B":     g = pack_cols(7'h7F, 7'h49, 7'h49, 7'h49, 7'h36);
            "D":     g = pack_cols(7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C);
            "E":     g = pack_cols(7'h7F, 7'h49, 7'h49, 7'h49, 7'h41);
            "F":     g = pack_cols(7'h7F, 7'h09, 7'h09, 7'h09, 7'h01);
            "G":     g = pack_cols(7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A);
            "I":     g = pack_cols(7'h00, 7'h41, 7'h7F, 7'h41, 7'h00);
            "L":     g = pack_cols(7'h7F, 7'h40, 7'h40, 7'h40, 7'h40);
            "M":     g = pack_cols(7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F);
            "N":     g = pack_cols(7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F);
            "O":     g = pack_cols(7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E);
            "P":     g = pack_cols(7'h7F, 7'h09, 7'h09, 7'h09, 7'h06);
            "R":     g = pack_cols(7'h7F, 7'h09, 7'h19, 7'h29, 7'h46);
            "S":     g = pack_cols(7'h46, 7'h49, 7'h49, 7'h49, 7'h31);
            "T":     g = pack_cols(7'h01, 7'h01, 7'h7F, 7'h01, 7'h01);
            "Y":     g = pack_cols(7'h03, 7'h04, 7'h78, 7'h04, 7'h03);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ----- sv/g2r_in_if.sv -----
// character channel: valid, ready and one character word
interface g2r_in_if;
    logic        valid;
    logic        ready;
    logic        new_text;
    logic [15:0] start_x;
    logic [15:0] top_y;
    logic [7:0]  char_code;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [7:0]  scale;

    modport source (output valid, new_text, start_x, top_y, char_code, fg_color, bg_color,
                    scale, input ready);
    modport sink (input valid, new_text, start_x, top_y, char_code, fg_color, bg_color,
                  scale, output ready);
endinterface

// ----- sv/g2r_out_if.sv -----
// rectangle channel: valid, ready and one rectangle word
interface g2r_out_if;
    logic        valid;
    logic        ready;
    logic        visible;
    logic [8:0]  left;
    logic [7:0]  top;
    logic [8:0]  right;
    logic [7:0]  bottom;
    logic [15:0] fill_color;
    logic [16:0] pixel_count;
    logic        last;

    modport source (output valid, visible, left, top, right, bottom, fill_color, pixel_count,
                    last, input ready);
    modport sink (input valid, visible, left, top, right, bottom, fill_color, pixel_count,
                  last, output ready);
endinterface

// ----- sv/g2r_front.sv -----
// front end: accepts characters, keeps the text cursor, looks up the glyph
module g2r_front
    import g2r_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    g2r_in_if.sink       char_in,
    output logic         push,
    output cmd_t         push_cmd,
    input  logic         full
);

    logic [15:0] cursor_reg;
    logic [15:0] cursor_next;
    logic [15:0] base_x;
    logic [7:0]  cell_px;
    logic [10:0] advance;

    // accept whenever the queue has room
    assign char_in.ready = !full;
    assign push          = char_in.valid && !full;

    // zero scale counts as one
    assign cell_px = (char_in.scale == 8'd0) ? 8'd1 : char_in.scale;
    assign base_x  = char_in.new_text ? char_in.start_x : cursor_reg;
    assign advance = {1'b0, cell_px, 2'b00} + {2'b00, cell_px, 1'b0};

    // command word for the back end
    always_comb
    begin
        push_cmd.x0      = base_x;
        push_cmd.y0      = char_in.top_y;
        push_cmd.cell_px = cell_px;
        push_cmd.glyph   = glyph_lookup(char_in.char_code);
        push_cmd.fg      = char_in.fg_color;
        push_cmd.bg      = char_in.bg_color;
    end

    // cursor moves six cells per character
    assign cursor_next = base_x + {5'd0, advance};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
        end
        else if (push)
        begin
            cursor_reg <= cursor_next;
        end
    end

endmodule

// ----- sv/g2r_queue.sv -----
// two-entry command queue between front and back
module g2r_queue
    import g2r_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic avail,
    output cmd_t head
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign avail = (count_reg != 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- sv/g2r_back.sv -----
// back end: walks the 36 rectangles of a character, clips them, counts pixels
module g2r_back
    import g2r_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      avail,
    input  cmd_t      head,
    output logic      pop,
    g2r_out_if.source rect_out
);

    // generator
    logic        gen_v_reg;
    cmd_t        cmd_reg;
    logic [2:0]  col_reg;
    logic [2:0]  row_reg;
    logic [15:0] cx_reg;
    logic [15:0] cy_reg;

    // clip stage
    logic                 s2_v_reg;
    logic                 s2_vis_reg;
    logic [DIM_W-1:0]     s2_x_reg;
    logic [DIM_W-1:0]     s2_y_reg;
    logic [DIM_W-1:0]     s2_x1_reg;
    logic [DIM_W-1:0]     s2_y1_reg;
    logic [DIM_W-1:0]     s2_dw_reg;
    logic [DIM_W-1:0]     s2_dh_reg;
    logic [15:0]          s2_color_reg;
    logic                 s2_last_reg;

    // output register
    logic        out_v_reg;
    logic        out_vis_reg;
    logic [8:0]  out_left_reg;
    logic [7:0]  out_top_reg;
    logic [8:0]  out_right_reg;
    logic [7:0]  out_bottom_reg;
    logic [15:0] out_color_reg;
    logic [16:0] out_count_reg;
    logic        out_last_reg;

    logic s3_free;
    logic s2_free;
    logic step;
    logic final_step;
    logic is_space;

    logic [2:0]  col_idx;
    logic        cell_bit;
    logic [10:0] w_raw;
    logic [10:0] h_raw;
    logic [15:0] color_raw;
    logic        vis;
    logic [DIM_W:0]   room_x;
    logic [DIM_W:0]   room_y;
    logic             fit_x;
    logic             fit_y;
    logic [DIM_W:0]   far_x;
    logic [DIM_W:0]   far_y;
    logic [DIM_W-1:0] dw;
    logic [DIM_W-1:0] dh;
    logic [DIM_W-1:0] x1;
    logic [DIM_W-1:0] y1;
    logic [2*DIM_W-1:0] area;

    // stall chain from the output back to the generator
    assign s3_free    = !out_v_reg || rect_out.ready;
    assign s2_free    = !s2_v_reg || s3_free;
    assign step       = gen_v_reg && s2_free;
    assign is_space   = (col_reg == SPACE_COL);
    assign final_step = step && is_space;
    assign pop        = avail && (!gen_v_reg || final_step);

    // generator walks the rows of each column, then the next column, keeping cell origins by adding the cell size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_v_reg <= 1'b0;
        end
        else if (pop)
        begin
            gen_v_reg <= 1'b1;
        end
        else if (final_step)
        begin
            gen_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
            col_reg <= 3'd0;
            row_reg <= 3'd0;
            cx_reg  <= head.x0;
            cy_reg  <= head.y0;
        end
        else if (step && !is_space)
        begin
            if (row_reg == LAST_ROW)
            begin
                row_reg <= 3'd0;
                col_reg <= col_reg + 3'd1;
                cx_reg  <= cx_reg + {8'd0, cmd_reg.cell_px};
                cy_reg  <= cmd_reg.y0;
            end
            else
            begin
                row_reg <= row_reg + 3'd1;
                cy_reg  <= cy_reg + {8'd0, cmd_reg.cell_px};
            end
        end
    end

    // raw rectangle of the current cell or of the spacing column
    assign col_idx   = is_space ? 3'd0 : col_reg;
    assign cell_bit  = !is_space && cmd_reg.glyph[col_idx][row_reg];
    assign color_raw = cell_bit ? cmd_reg.fg : cmd_reg.bg;
    assign w_raw     = {3'd0, cmd_reg.cell_px};
    assign h_raw     = is_space ? ({cmd_reg.cell_px, 3'd0} - {3'd0, cmd_reg.cell_px}) : w_raw;

    // clipping against the screen edges
    assign vis    = (cx_reg < SCREEN_W16) && (cy_reg < SCREEN_H16);
    assign room_x = {1'b0, SCREEN_WD} - {1'b0, cx_reg[DIM_W-1:0]};
    assign room_y = {1'b0, SCREEN_HD} - {1'b0, cy_reg[DIM_W-1:0]};
    assign fit_x  = ((DIM_W+1)'(w_raw) <= room_x);
    assign fit_y  = ((DIM_W+1)'(h_raw) <= room_y);
    assign far_x  = {1'b0, cx_reg[DIM_W-1:0]} + (DIM_W+1)'(w_raw) - (DIM_W+1)'(1);
    assign far_y  = {1'b0, cy_reg[DIM_W-1:0]} + (DIM_W+1)'(h_raw) - (DIM_W+1)'(1);
    assign dw     = fit_x ? DIM_W'(w_raw) : room_x[DIM_W-1:0];
    assign dh     = fit_y ? DIM_W'(h_raw) : room_y[DIM_W-1:0];
    assign x1     = fit_x ? far_x[DIM_W-1:0] : (SCREEN_WD - DIM_W'(1));
    assign y1     = fit_y ? far_y[DIM_W-1:0] : (SCREEN_HD - DIM_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_v_reg <= gen_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s2_vis_reg   <= vis;
            s2_x_reg     <= cx_reg[DIM_W-1:0];
            s2_y_reg     <= cy_reg[DIM_W-1:0];
            s2_x1_reg    <= x1;
            s2_y1_reg    <= y1;
            s2_dw_reg    <= dw;
            s2_dh_reg    <= dh;
            s2_color_reg <= color_raw;
            s2_last_reg  <= is_space;
        end
    end

    // pixel count and zeroing of off-screen rectangles
    assign area = s2_dw_reg * s2_dh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (s3_free)
        begin
            out_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_free && s2_v_reg)
        begin
            out_vis_reg    <= s2_vis_reg;
            out_left_reg   <= s2_vis_reg ? s2_x_reg[8:0] : 9'd0;
            out_top_reg    <= s2_vis_reg ? s2_y_reg[7:0] : 8'd0;
            out_right_reg  <= s2_vis_reg ? s2_x1_reg[8:0] : 9'd0;
            out_bottom_reg <= s2_vis_reg ? s2_y1_reg[7:0] : 8'd0;
            out_count_reg  <= s2_vis_reg ? area[16:0] : 17'd0;
            out_color_reg  <= s2_color_reg;
            out_last_reg   <= s2_last_reg;
        end
    end

    // output word
    assign rect_out.valid       = out_v_reg;
    assign rect_out.visible     = out_vis_reg;
    assign rect_out.left        = out_left_reg;
    assign rect_out.top         = out_top_reg;
    assign rect_out.right       = out_right_reg;
    assign rect_out.bottom      = out_bottom_reg;
    assign rect_out.fill_color  = out_color_reg;
    assign rect_out.pixel_count = out_count_reg;
    assign rect_out.last        = out_last_reg;

endmodule

// ----- sv/glyph_to_rect_rasterizer_unit.sv -----
// top level of the glyph rasterizer: front end, command queue, back end
// a character's first rectangle word passes the queue, generator, clip and output registers
// one rectangle word per cycle from the back end walker while the output is not stalled
// the front end takes a new character while the back end still draws, up to two queued
// reset: asynchronous, clears the text cursor to zero, empties the queue and all valid flags
// no clearing pass after reset, the block accepts in the first cycle out of reset
module glyph_to_rect_rasterizer_unit
    import g2r_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    g2r_in_if.sink    char_in,
    g2r_out_if.source rect_out
);

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic avail;
    cmd_t head;

    // look up glyphs and place characters
    g2r_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_in),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full)
    );

    // decouple front and back
    g2r_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .avail    (avail),
        .head     (head)
    );

    // draw rectangles
    g2r_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .avail    (avail),
        .head     (head),
        .pop      (pop),
        .rect_out (rect_out)
    );

endmodule

// ----- sv/g2r_checker.sv -----
// port-level assertions for the glyph rasterizer and their bind
module g2r_checker
    import g2r_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic        visible,
    input logic [8:0]  left,
    input logic [7:0]  top,
    input logic [8:0]  right,
    input logic [7:0]  bottom,
    input logic [15:0] fill_color,
    input logic [16:0] pixel_count,
    input logic        last
);

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable({visible, left, top, right, bottom, fill_color,
                                              pixel_count, last}))
        else $error("stalled rectangle word changed");

    // off-screen words carry no geometry
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !visible |-> left == 9'd0 && top == 8'd0 && right == 9'd0 &&
                              bottom == 8'd0 && pixel_count == 17'd0)
        else $error("invisible rectangle has geometry");

    // on-screen words are ordered and lie inside the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && visible |-> right >= left && bottom >= top &&
                             {7'd0, right} < SCREEN_W16 && {8'd0, bottom} < SCREEN_H16)
        else $error("visible rectangle out of order or off screen");

    // pixel count matches the clipped edges
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && visible |-> pixel_count ==
            17'(({8'd0, right} - {8'd0, left} + 17'd1) * ({9'd0, bottom} - {9'd0, top} + 17'd1)))
        else $error("pixel count does not match rectangle");

    // no word during reset
    assert property (@(posedge clk) !rst_n |-> !valid)
        else $error("rectangle word during reset");

endmodule

bind glyph_to_rect_rasterizer_unit g2r_checker u_g2r_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (rect_out.valid),
    .ready       (rect_out.ready),
    .visible     (rect_out.visible),
    .left        (rect_out.left),
    .top         (rect_out.top),
    .right       (rect_out.right),
    .bottom      (rect_out.bottom),
    .fill_color  (rect_out.fill_color),
    .pixel_count (rect_out.pixel_count),
    .last        (rect_out.last)
);
